>>> hdl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// shared types, codes and defaults of the first-fit heap allocator
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int DEF_OFFSET_BITS   = 24;
    localparam int HEAP_BITS         = 24;
    localparam int ALIGN_BITS        = 13;
    localparam int CNT_BITS          = 7;
    localparam int HEAP_RESET        = 65536;
    localparam int DEFAULT_ALIGN     = 4;

    localparam logic REG_HEAP  = 1'b0;
    localparam logic REG_ALIGN = 1'b1;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RD,
        S_EVAL,
        S_MOD,
        S_FIT,
        S_TAKE
    } t_state;

    typedef struct packed {
        logic    init_wr;
        logic    accept;
        logic    rd;
        logic    next;
        logic    div_start;
        logic    div_step;
        logic    split_wr;
        logic    take_wr;
        logic    free_wr;
        logic    respond;
        t_status code;
    } t_ctrl;

    typedef struct packed {
        logic is_free;
        logic match;
        logic fits;
        logic exact;
        logic last;
        logic full;
        logic div_done;
        logic zero_size;
        logic cmd_free;
    } t_dp_stat;

endpackage

>>> hdl/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// sequencer for table scan, alignment remainder and table updates
// ----------------------------------------------------------------------------
module ffha_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_reinit,
    input  logic              i_start,
    input  ffha_pkg::t_dp_stat i_stat,
    output ffha_pkg::t_ctrl   o_ctrl,
    output logic              o_busy
);

    ffha_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffha_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffha_pkg::S_INIT: n_state = i_reinit ? ffha_pkg::S_INIT : ffha_pkg::S_IDLE;
            ffha_pkg::S_IDLE: begin
                priority if (i_reinit) n_state = ffha_pkg::S_INIT;
                else if (i_start)      n_state = ffha_pkg::S_RD;
                else                   n_state = ffha_pkg::S_IDLE;
            end
            ffha_pkg::S_RD: n_state = ffha_pkg::S_EVAL;
            ffha_pkg::S_EVAL: begin
                if (i_stat.cmd_free) begin
                    if ((!i_stat.is_free && i_stat.match) || i_stat.last)
                        n_state = ffha_pkg::S_IDLE;
                    else
                        n_state = ffha_pkg::S_RD;
                end else begin
                    priority if (i_stat.zero_size) n_state = ffha_pkg::S_IDLE;
                    else if (i_stat.is_free)       n_state = ffha_pkg::S_MOD;
                    else if (i_stat.last)          n_state = ffha_pkg::S_IDLE;
                    else                           n_state = ffha_pkg::S_RD;
                end
            end
            ffha_pkg::S_MOD: begin
                if (i_stat.div_done) n_state = ffha_pkg::S_FIT;
            end
            ffha_pkg::S_FIT: begin
                priority if (i_stat.fits && !i_stat.exact && !i_stat.full)
                    n_state = ffha_pkg::S_TAKE;
                else if (i_stat.fits || i_stat.last)
                    n_state = ffha_pkg::S_IDLE;
                else
                    n_state = ffha_pkg::S_RD;
            end
            ffha_pkg::S_TAKE: n_state = ffha_pkg::S_IDLE;
            default: n_state = ffha_pkg::S_INIT;
        endcase
    end

    always_comb begin
        o_ctrl      = '0;
        o_ctrl.code = ffha_pkg::ST_OK;
        unique case (r_state)
            ffha_pkg::S_INIT: o_ctrl.init_wr = 1'b1;
            ffha_pkg::S_IDLE: o_ctrl.accept = i_start && !i_reinit;
            ffha_pkg::S_RD:   o_ctrl.rd = 1'b1;
            ffha_pkg::S_EVAL: begin
                if (i_stat.cmd_free) begin
                    priority if (!i_stat.is_free && i_stat.match) begin
                        o_ctrl.free_wr = 1'b1;
                        o_ctrl.respond = 1'b1;
                    end else if (i_stat.last) begin
                        o_ctrl.respond = 1'b1;
                        o_ctrl.code    = ffha_pkg::ST_NOT_FOUND;
                    end else begin
                        o_ctrl.next = 1'b1;
                    end
                end else begin
                    priority if (i_stat.zero_size) begin
                        o_ctrl.respond = 1'b1;
                        o_ctrl.code    = ffha_pkg::ST_NO_FIT;
                    end else if (i_stat.is_free) begin
                        o_ctrl.div_start = 1'b1;
                    end else if (i_stat.last) begin
                        o_ctrl.respond = 1'b1;
                        o_ctrl.code    = ffha_pkg::ST_NO_FIT;
                    end else begin
                        o_ctrl.next = 1'b1;
                    end
                end
            end
            ffha_pkg::S_MOD: o_ctrl.div_step = 1'b1;
            ffha_pkg::S_FIT: begin
                priority if (i_stat.fits && i_stat.exact) begin
                    o_ctrl.take_wr = 1'b1;
                    o_ctrl.respond = 1'b1;
                end else if (i_stat.fits && i_stat.full) begin
                    o_ctrl.respond = 1'b1;
                    o_ctrl.code    = ffha_pkg::ST_FULL;
                end else if (i_stat.fits) begin
                    o_ctrl.split_wr = 1'b1;
                end else if (i_stat.last) begin
                    o_ctrl.respond = 1'b1;
                    o_ctrl.code    = ffha_pkg::ST_NO_FIT;
                end else begin
                    o_ctrl.next = 1'b1;
                end
            end
            ffha_pkg::S_TAKE: begin
                o_ctrl.take_wr = 1'b1;
                o_ctrl.respond = 1'b1;
            end
            default: o_ctrl.init_wr = 1'b1;
        endcase
    end

    assign o_busy = (r_state != ffha_pkg::S_IDLE);

endmodule

>>> hdl/ffha_dp.sv
// ----------------------------------------------------------------------------
// ffha_dp
// block table memory, remainder unit, counters and result registers
// ----------------------------------------------------------------------------
module ffha_dp #(
    parameter int TABLE_ENTRIES = ffha_pkg::DEF_TABLE_ENTRIES,
    parameter int OFFSET_BITS   = ffha_pkg::DEF_OFFSET_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ffha_pkg::t_ctrl                 i_ctrl,
    input  logic [ffha_pkg::HEAP_BITS-1:0]  i_heap,
    input  logic [ffha_pkg::ALIGN_BITS-1:0] i_align,
    input  logic                            i_cmd,
    input  logic [OFFSET_BITS-1:0]          i_req_size,
    input  logic [OFFSET_BITS-1:0]          i_cell_offset,
    output ffha_pkg::t_dp_stat              o_stat,
    output logic                            o_done,
    output logic [1:0]                      o_status,
    output logic [OFFSET_BITS-1:0]          o_granted_offset,
    output logic [OFFSET_BITS-1:0]          o_bytes_in_use,
    output logic [ffha_pkg::CNT_BITS-1:0]   o_cells_in_use
);

    localparam int IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int UW  = $clog2(TABLE_ENTRIES + 1);
    localparam int EW  = 1 + 2 * OFFSET_BITS;
    localparam int AB  = ffha_pkg::ALIGN_BITS;
    localparam int WW  = ((OFFSET_BITS > AB) ? OFFSET_BITS : AB) + 1;
    localparam int DCW = $clog2(OFFSET_BITS);

    logic [EW-1:0] r_mem [TABLE_ENTRIES];
    logic [EW-1:0] r_rd_data;

    logic [IW-1:0]                  r_idx;
    logic [UW-1:0]                  r_used;
    logic [OFFSET_BITS-1:0]         r_total;
    logic [ffha_pkg::CNT_BITS-1:0]  r_cells;
    logic                           r_cmd;
    logic [OFFSET_BITS-1:0]         r_size;
    logic [OFFSET_BITS-1:0]         r_ofs;
    logic [AB-1:0]                  r_rem;
    logic [OFFSET_BITS-1:0]         r_dvd;
    logic [DCW-1:0]                 r_dcnt;
    logic                           r_done;
    logic [1:0]                     r_status;
    logic [OFFSET_BITS-1:0]         r_granted;

    logic                   e_free;
    logic [OFFSET_BITS-1:0] e_start, e_len;
    logic [AB-1:0]          al, pad;
    logic [AB:0]            trial;
    logic [WW-1:0]          len_w, pad_w, size_w, avail_w;
    logic [OFFSET_BITS-1:0] start_al;
    logic                   wr_en;
    logic [IW-1:0]          wr_addr;
    logic [EW-1:0]          wr_data;

    assign e_free  = r_rd_data[EW-1];
    assign e_start = r_rd_data[2*OFFSET_BITS-1:OFFSET_BITS];
    assign e_len   = r_rd_data[OFFSET_BITS-1:0];

    assign al    = (i_align == '0) ? AB'(ffha_pkg::DEFAULT_ALIGN) : i_align;
    assign trial = {r_rem, r_dvd[OFFSET_BITS-1]};
    assign pad   = (r_rem == '0) ? '0 : AB'(al - r_rem);

    assign len_w    = WW'(e_len);
    assign pad_w    = WW'(pad);
    assign size_w   = WW'(r_size);
    assign avail_w  = len_w - pad_w;
    assign start_al = OFFSET_BITS'(e_start + OFFSET_BITS'(pad));

    always_comb begin
        o_stat.is_free   = e_free;
        o_stat.match     = (e_start == r_ofs);
        o_stat.fits      = (len_w >= pad_w) && (avail_w >= size_w);
        o_stat.exact     = (avail_w == size_w);
        o_stat.last      = (UW'(r_idx) + UW'(1)) >= r_used;
        o_stat.full      = (r_used >= UW'(TABLE_ENTRIES));
        o_stat.div_done  = (r_dcnt == DCW'(OFFSET_BITS - 1));
        o_stat.zero_size = (r_size == '0);
        o_stat.cmd_free  = (r_cmd == ffha_pkg::CMD_FREE);
    end

    // one write port shared by init, split, take and free
    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_idx;
        wr_data = r_rd_data;
        priority if (i_ctrl.init_wr) begin
            wr_addr = '0;
            wr_data = {1'b1, {OFFSET_BITS{1'b0}}, OFFSET_BITS'(i_heap)};
        end else if (i_ctrl.split_wr) begin
            wr_addr = r_used[IW-1:0];
            wr_data = {1'b1, OFFSET_BITS'(start_al + r_size),
                       OFFSET_BITS'(avail_w - size_w)};
        end else if (i_ctrl.take_wr) begin
            wr_data = {1'b0, start_al, r_size};
        end else if (i_ctrl.free_wr) begin
            wr_data = {1'b1, e_start, e_len};
        end else begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (i_ctrl.rd) r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= UW'(1);
            r_total <= '0;
            r_cells <= '0;
            r_idx   <= '0;
            r_dcnt  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_ctrl.respond;
            if (i_ctrl.init_wr) begin
                r_used  <= UW'(1);
                r_total <= '0;
                r_cells <= '0;
            end
            if (i_ctrl.accept) r_idx <= '0;
            if (i_ctrl.next)   r_idx <= IW'(r_idx + 1'b1);
            if (i_ctrl.split_wr) r_used <= UW'(r_used + 1'b1);
            if (i_ctrl.take_wr) begin
                r_total <= OFFSET_BITS'(r_total + r_size);
                r_cells <= ffha_pkg::CNT_BITS'(r_cells + 1'b1);
            end
            if (i_ctrl.free_wr) begin
                r_total <= OFFSET_BITS'(r_total - e_len);
                r_cells <= ffha_pkg::CNT_BITS'(r_cells - 1'b1);
            end
            if (i_ctrl.div_start) r_dcnt <= '0;
            if (i_ctrl.div_step)  r_dcnt <= DCW'(r_dcnt + 1'b1);
        end
    end

    // restoring remainder, one dividend bit a cycle from the top
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_cmd  <= i_cmd;
            r_size <= i_req_size;
            r_ofs  <= i_cell_offset;
        end
        if (i_ctrl.div_start) begin
            r_rem <= '0;
            r_dvd <= e_start;
        end
        if (i_ctrl.div_step) begin
            r_rem <= (trial >= {1'b0, al}) ? AB'(trial - {1'b0, al}) : AB'(trial);
            r_dvd <= {r_dvd[OFFSET_BITS-2:0], 1'b0};
        end
        if (i_ctrl.respond) begin
            r_status  <= i_ctrl.code;
            r_granted <= (i_ctrl.code == ffha_pkg::ST_OK && r_cmd == ffha_pkg::CMD_ALLOC)
                         ? start_al : '0;
        end
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_granted_offset = r_granted;
    assign o_bytes_in_use   = r_total;
    assign o_cells_in_use   = r_cells;

`ifndef SYNTHESIS
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used != '0) && (r_used <= UW'(TABLE_ENTRIES)))
        else $error("entry count out of range");
    a_split_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.split_wr |-> (r_used < UW'(TABLE_ENTRIES)) && e_free)
        else $error("split without room or on a taken entry");
    a_take_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.take_wr |-> e_free && o_stat.fits)
        else $error("cell taken from an entry that does not fit");
    a_split_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.split_wr |=> i_ctrl.take_wr)
        else $error("split not followed by take");
`endif

endmodule

>>> hdl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// first-fit allocator over a table of heap blocks, results are offsets
// ----------------------------------------------------------------------------
// channel   direction  handshake                  payload
// request   in         start & !busy              i_cmd, i_req_size, i_cell_offset
// result    out        o_done, one cycle          o_status, o_granted_offset,
//                                                 o_bytes_in_use, o_cells_in_use
// config    in/out     psel & penable & pwrite    paddr, pwdata, prdata, pready
//
// a request reads and evaluates each table entry it visits; for each free
// entry an allocate inspects it also computes a bit-serial remainder by the
// alignment, and a block that is split is written in an extra take state
// after reset, and after a heap write while idle, the init state rebuilds
// the table, busy high; results cannot be stalled and show for exactly one cycle
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
    parameter int TABLE_ENTRIES = ffha_pkg::DEF_TABLE_ENTRIES,
    parameter int OFFSET_BITS   = ffha_pkg::DEF_OFFSET_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cmd,
    input  logic [OFFSET_BITS-1:0]        i_req_size,
    input  logic [OFFSET_BITS-1:0]        i_cell_offset,
    output logic                          o_done,
    output logic [1:0]                    o_status,
    output logic [OFFSET_BITS-1:0]        o_granted_offset,
    output logic [OFFSET_BITS-1:0]        o_bytes_in_use,
    output logic [ffha_pkg::CNT_BITS-1:0] o_cells_in_use,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [ffha_pkg::HEAP_BITS-1:0]  r_heap;
    logic [ffha_pkg::ALIGN_BITS-1:0] r_align;
    logic                            cfg_wr, reinit;
    ffha_pkg::t_ctrl                 ctrl;
    ffha_pkg::t_dp_stat              stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign reinit = cfg_wr && (paddr[2] == ffha_pkg::REG_HEAP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap  <= ffha_pkg::HEAP_BITS'(ffha_pkg::HEAP_RESET);
            r_align <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == ffha_pkg::REG_HEAP) r_heap <= pwdata[ffha_pkg::HEAP_BITS-1:0];
            else                                r_align <= pwdata[ffha_pkg::ALIGN_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == ffha_pkg::REG_ALIGN)
                    ? {{(32 - ffha_pkg::ALIGN_BITS){1'b0}}, r_align}
                    : {{(32 - ffha_pkg::HEAP_BITS){1'b0}}, r_heap};

    ffha_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_reinit (reinit),
        .i_start  (start),
        .i_stat   (stat),
        .o_ctrl   (ctrl),
        .o_busy   (busy)
    );

    ffha_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .OFFSET_BITS   (OFFSET_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (ctrl),
        .i_heap           (r_heap),
        .i_align          (r_align),
        .i_cmd            (i_cmd),
        .i_req_size       (i_req_size),
        .i_cell_offset    (i_cell_offset),
        .o_stat           (stat),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_granted_offset (o_granted_offset),
        .o_bytes_in_use   (o_bytes_in_use),
        .o_cells_in_use   (o_cells_in_use)
    );

endmodule
